/* hw/rtl/cubic_bspline_evaluator_defines.svh */
// Assertion macros shared by the evaluator RTL.
`ifndef CUBIC_BSPLINE_EVALUATOR_DEFINES_SVH
`define CUBIC_BSPLINE_EVALUATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CBS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define CBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/cbs_pkg.sv */
// Types, constants and microcode program of the cubic B-spline evaluator.
package cbs_pkg;

   localparam int DATA_W      = 32;
   localparam int IDX_W       = 6;
   localparam int COUNT_W     = 6;
   localparam int FRAC_W      = 16;
   localparam int POW_W       = 17;
   localparam int WEIGHT_W    = 19;
   localparam int ACC_W       = 54;
   localparam int MUL_W       = 33;
   localparam int PROD_W      = 64;
   localparam int STEP_W      = 4;
   localparam int CSR_INDEX_W = 2;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_KNOT_START  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_SPACING = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NODE_COUNT  = 2'd2;

   localparam logic [DATA_W-1:0]  KNOT_START_RESET  = 32'd0;
   localparam logic [DATA_W-1:0]  INV_SPACING_RESET = 32'd65536;
   localparam logic [COUNT_W-1:0] NODE_COUNT_RESET  = 6'd14;

   localparam logic [POW_W-1:0] ONE_Q16      = 17'h10000;
   localparam int               WEIGHT_THREE = 3;

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_FETCH      = 4'd0;
   localparam step_type STEP_FIRST_WORK = 4'd1;
   localparam step_type STEP_EMIT       = 4'd12;
   localparam step_type PROG_LAST       = 4'd12;

   typedef enum logic [2:0] {
      OPA_ZERO, OPA_ABSD, OPA_T, OPA_T2, OPA_U, OPA_U2, OPA_COEF
   } opa_type;

   typedef enum logic [2:0] {
      OPB_ZERO, OPB_INV, OPB_T, OPB_U, OPB_W0, OPB_W1, OPB_W2, OPB_W3
   } opb_type;

   typedef enum logic [2:0] {
      DST_NONE, DST_PROD, DST_T2, DST_T3, DST_U2, DST_U3
   } dst_type;

   typedef enum logic [1:0] {
      ACC_HOLD, ACC_LOAD, ACC_ADD
   } acc_type;

   typedef enum logic [1:0] {
      COND_NEVER, COND_ALWAYS, COND_NO_EVAL, COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      logic       accept;
      opa_type    opa;
      opb_type    opb;
      dst_type    dst;
      logic       split;
      logic       wload;
      logic       rd_en;
      logic [1:0] rd_k;
      acc_type    acc;
      logic       emit;
      cond_type   cond;
      step_type   target;
   } ctl_type;

   typedef struct packed {
      logic eval_start;
      logic out_busy;
   } stat_type;

   typedef struct packed {
      step_type step;
      ctl_type  ctl;
   } seq_out_type;

   typedef struct packed {
      logic [DATA_W-1:0]  knot_start;
      logic [DATA_W-1:0]  inverse_spacing;
      logic [COUNT_W-1:0] node_count;
   } cfg_type;

   localparam ctl_type CTL_NOP = '{
      accept: 1'b0, opa: OPA_ZERO, opb: OPB_ZERO, dst: DST_NONE,
      split: 1'b0, wload: 1'b0, rd_en: 1'b0, rd_k: 2'd0,
      acc: ACC_HOLD, emit: 1'b0, cond: COND_NEVER, target: STEP_FETCH
   };

   // Microcode ROM: one control word per step.
   function automatic ctl_type ucode(input step_type step);
      ctl_type w;
      w = CTL_NOP;
      unique case (step)
         4'd0: begin
            w.accept = 1'b1;
            w.cond   = COND_NO_EVAL;
            w.target = STEP_FETCH;
         end
         4'd1: begin
            w.opa = OPA_ABSD; w.opb = OPB_INV; w.dst = DST_PROD;
         end
         4'd2: begin
            w.split = 1'b1;
         end
         4'd3: begin
            w.opa = OPA_T; w.opb = OPB_T; w.dst = DST_T2;
         end
         4'd4: begin
            w.opa = OPA_T2; w.opb = OPB_T; w.dst = DST_T3;
         end
         4'd5: begin
            w.opa = OPA_U; w.opb = OPB_U; w.dst = DST_U2;
         end
         4'd6: begin
            w.opa = OPA_U2; w.opb = OPB_U; w.dst = DST_U3;
            w.rd_en = 1'b1; w.rd_k = 2'd0;
         end
         4'd7: begin
            w.opa = OPA_COEF; w.opb = OPB_W0; w.dst = DST_PROD;
            w.wload = 1'b1;
            w.rd_en = 1'b1; w.rd_k = 2'd1;
         end
         4'd8: begin
            w.opa = OPA_COEF; w.opb = OPB_W1; w.dst = DST_PROD;
            w.acc = ACC_LOAD;
            w.rd_en = 1'b1; w.rd_k = 2'd2;
         end
         4'd9: begin
            w.opa = OPA_COEF; w.opb = OPB_W2; w.dst = DST_PROD;
            w.acc = ACC_ADD;
            w.rd_en = 1'b1; w.rd_k = 2'd3;
         end
         4'd10: begin
            w.opa = OPA_COEF; w.opb = OPB_W3; w.dst = DST_PROD;
            w.acc = ACC_ADD;
         end
         4'd11: begin
            w.acc = ACC_ADD;
         end
         4'd12: begin
            w.emit   = 1'b1;
            w.cond   = COND_OUT_BUSY;
            w.target = STEP_EMIT;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_FETCH;
         end
      endcase
      return w;
   endfunction

endpackage

/* hw/rtl/cbs_if.sv */
// Channel interfaces: request, response and register write.
interface cbs_req_if import cbs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              command;
   logic [IDX_W-1:0]  coef_index;
   logic [DATA_W-1:0] coef_value;
   logic [DATA_W-1:0] x_value;

   modport source (output valid, command, coef_index, coef_value, x_value, input ready);
   modport sink   (input valid, command, coef_index, coef_value, x_value, output ready);
endinterface

interface cbs_rsp_if import cbs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] spline_value;

   modport source (output valid, spline_value, input ready);
   modport sink   (input valid, spline_value, output ready);
endinterface

interface cbs_csr_if import cbs_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [DATA_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/cbs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module cbs_ram #(
   parameter int  WIDTH  = 32,
   parameter int  DEPTH  = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/cbs_sequencer.sv */
// Microcode sequencer: step counter, control ROM and conditional jumps.
module cbs_sequencer import cbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  stat_type    stat,
   output seq_out_type seq
);

   step_type step_ff, step_in;
   ctl_type  ctl;
   logic     taken;

   assign ctl = ucode(step_ff);

   always_comb begin
      unique case (ctl.cond)
         COND_NEVER:    taken = 1'b0;
         COND_ALWAYS:   taken = 1'b1;
         COND_NO_EVAL:  taken = !stat.eval_start;
         COND_OUT_BUSY: taken = stat.out_busy;
         default:       taken = 1'b0;
      endcase
   end

   always_comb begin
      if (taken) begin
         step_in = ctl.target;
      end else if (step_ff == PROG_LAST) begin
         step_in = STEP_FETCH;
      end else begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_FETCH;
      end else begin
         step_ff <= step_in;
      end
   end

   assign seq.step = step_ff;
   assign seq.ctl  = ctl;

endmodule

/* hw/rtl/cbs_datapath.sv */
// Datapath: shared multiplier, power and weight registers, accumulator, table.
module cbs_datapath import cbs_pkg::*; #(
   parameter int COEF_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  ctl_type           ctl,
   input  cfg_type           cfg,
   input  logic              req_fire,
   input  logic              command,
   input  logic [IDX_W-1:0]  coef_index,
   input  logic [DATA_W-1:0] coef_value,
   input  logic [DATA_W-1:0] x_value,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [DATA_W-1:0] spline_value,
   output stat_type          stat
);

   localparam int ADDR_W = $clog2(COEF_DEPTH);
   localparam int J_W    = MUL_W + 2;
   localparam int R_W    = ACC_W - FRAC_W;

   logic [DATA_W-1:0]         absd_ff;
   logic                      neg_ff;
   logic [PROD_W-1:0]         prod_ff;
   logic signed [MUL_W-1:0]   m_ff;
   logic [FRAC_W-1:0]         t_ff;
   logic [POW_W-1:0]          u_ff, t2_ff, t3_ff, u2_ff, u3_ff;
   logic [WEIGHT_W-1:0]       w1_ff, w2_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic                      coef_ok_ff;
   logic                      rsp_valid_ff;
   logic [DATA_W-1:0]         rsp_data_ff;

   logic                      eval_start, load_we, emit_fire;
   logic [MUL_W-1:0]          diff, diff_neg;
   logic [DATA_W-1:0]         load_idx;
   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [2*MUL_W-1:0] mul_p;
   logic [PROD_W:0]           sp_mag, sp;
   logic [WEIGHT_W+1:0]       w1_sum, w2_sum;
   logic [J_W-1:0]            j;
   logic                      j_ok;
   logic [DATA_W-1:0]         rdata;
   logic [ADDR_W-1:0]         raddr, waddr;
   logic [R_W-1:0]            r;
   logic [DATA_W-1:0]         sat;

   assign eval_start = req_fire && (command == CMD_EVAL);

   // x - start in 33 bits; its magnitude always fits 32 bits
   assign diff     = {x_value[DATA_W-1], x_value}
                   - {cfg.knot_start[DATA_W-1], cfg.knot_start};
   assign diff_neg = ~diff + MUL_W'(1);

   // coefficient table
   assign load_idx = DATA_W'(coef_index);
   assign waddr    = load_idx[ADDR_W-1:0];
   assign load_we  = req_fire && (command == CMD_LOAD)
                   && (load_idx < DATA_W'(COEF_DEPTH));

   assign j     = {{2{m_ff[MUL_W-1]}}, m_ff} + {{(J_W-2){1'b0}}, ctl.rd_k};
   assign j_ok  = !j[J_W-1]
                && (j[J_W-2:0] <= (J_W-1)'(cfg.node_count) + (J_W-1)'(1))
                && (j[J_W-2:0] <  (J_W-1)'(COEF_DEPTH));
   assign raddr = j[ADDR_W-1:0];

   cbs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (COEF_DEPTH)
   ) u_coef_ram (
      .clock (clock),
      .we    (load_we),
      .waddr (waddr),
      .wdata (coef_value),
      .re    (ctl.rd_en),
      .raddr (raddr),
      .rdata (rdata)
   );

   // shared multiplier operand select
   always_comb begin
      unique case (ctl.opa)
         OPA_ZERO: mul_a = '0;
         OPA_ABSD: mul_a = {1'b0, absd_ff};
         OPA_T:    mul_a = {17'd0, t_ff};
         OPA_T2:   mul_a = {16'd0, t2_ff};
         OPA_U:    mul_a = {16'd0, u_ff};
         OPA_U2:   mul_a = {16'd0, u2_ff};
         OPA_COEF: mul_a = coef_ok_ff ? {rdata[DATA_W-1], rdata} : '0;
         default:  mul_a = '0;
      endcase
   end

   always_comb begin
      unique case (ctl.opb)
         OPB_ZERO: mul_b = '0;
         OPB_INV:  mul_b = {1'b0, cfg.inverse_spacing};
         OPB_T:    mul_b = {17'd0, t_ff};
         OPB_U:    mul_b = {16'd0, u_ff};
         OPB_W0:   mul_b = {16'd0, u3_ff};
         OPB_W1:   mul_b = {14'd0, w1_ff};
         OPB_W2:   mul_b = {14'd0, w2_ff};
         OPB_W3:   mul_b = {16'd0, t3_ff};
         default:  mul_b = '0;
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // signed scaled position; floor at 2^-16 is plain truncation
   assign sp_mag = {1'b0, prod_ff};
   assign sp     = neg_ff ? (~sp_mag + (PROD_W+1)'(1)) : sp_mag;

   assign w1_sum = (WEIGHT_W+2)'(ONE_Q16)
                 + (WEIGHT_W+2)'(u_ff)  * (WEIGHT_W+2)'(WEIGHT_THREE)
                 + (WEIGHT_W+2)'(u2_ff) * (WEIGHT_W+2)'(WEIGHT_THREE)
                 - (WEIGHT_W+2)'(u3_ff) * (WEIGHT_W+2)'(WEIGHT_THREE);
   assign w2_sum = (WEIGHT_W+2)'(ONE_Q16)
                 + (WEIGHT_W+2)'(t_ff)  * (WEIGHT_W+2)'(WEIGHT_THREE)
                 + (WEIGHT_W+2)'(t2_ff) * (WEIGHT_W+2)'(WEIGHT_THREE)
                 - (WEIGHT_W+2)'(t3_ff) * (WEIGHT_W+2)'(WEIGHT_THREE);

   // floor to Q16, then saturate
   assign r = acc_ff[ACC_W-1:FRAC_W];
   always_comb begin
      if ((&r[R_W-1:DATA_W-1]) || !(|r[R_W-1:DATA_W-1])) begin
         sat = r[DATA_W-1:0];
      end else if (r[R_W-1]) begin
         sat = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         sat = {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

   assign stat.eval_start = eval_start;
   assign stat.out_busy   = rsp_valid_ff && !rsp_ready;
   assign emit_fire       = ctl.emit && !stat.out_busy;

   always_ff @(posedge clock) begin
      if (eval_start) begin
         neg_ff  <= diff[MUL_W-1];
         absd_ff <= diff[MUL_W-1] ? diff_neg[DATA_W-1:0] : diff[DATA_W-1:0];
      end
      case (ctl.dst)
         DST_PROD: prod_ff <= mul_p[PROD_W-1:0];
         DST_T2:   t2_ff   <= mul_p[FRAC_W+POW_W-1:FRAC_W];
         DST_T3:   t3_ff   <= mul_p[FRAC_W+POW_W-1:FRAC_W];
         DST_U2:   u2_ff   <= mul_p[FRAC_W+POW_W-1:FRAC_W];
         DST_U3:   u3_ff   <= mul_p[FRAC_W+POW_W-1:FRAC_W];
         default: ;
      endcase
      if (ctl.split) begin
         m_ff <= sp[PROD_W:DATA_W];
         t_ff <= sp[DATA_W-1:FRAC_W];
         u_ff <= ONE_Q16 - {1'b0, sp[DATA_W-1:FRAC_W]};
      end
      if (ctl.wload) begin
         w1_ff <= w1_sum[WEIGHT_W-1:0];
         w2_ff <= w2_sum[WEIGHT_W-1:0];
      end
      if (ctl.rd_en) begin
         coef_ok_ff <= j_ok;
      end
      case (ctl.acc)
         ACC_LOAD: acc_ff <= signed'(prod_ff[ACC_W-1:0]);
         ACC_ADD:  acc_ff <= acc_ff + signed'(prod_ff[ACC_W-1:0]);
         default: ;
      endcase
      if (emit_fire) begin
         rsp_data_ff <= sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign spline_value = rsp_data_ff;

endmodule

/* hw/rtl/cubic_bspline_evaluator.sv */
// Top level of the uniform cubic B-spline evaluator.
//
// req_ch carries load and evaluate items; a transfer happens when valid and
// ready are both high. A load (command 0) writes coef_value into table entry
// coef_index in its transfer cycle and produces no response. An evaluate
// (command 1) produces one spline_value on rsp_ch. Evaluates run one at a
// time on a single shared 33x33 multiplier that forms nine products
// (position, four powers, four weighted coefficients), so an evaluate
// occupies the block until its program ends; loads sustain one per cycle
// in the fetch step. req_ch.ready is high only in the fetch step.
// csr_ch writes knot_start, inverse_spacing and node_count (index 0..2;
// index 3 is dropped); it is always ready. The user must write it only while
// idle; the block does not enforce it. The result sits in an output
// register: a new item is taken while it waits, and the sequencer holds in
// its last step only if the earlier result is still not taken by the sink.
// Reset returns the sequencer to fetch, empties the output register and loads
// the register defaults. The coefficient table is not cleared: entries must be
// loaded before an evaluate touches them.
`include "cubic_bspline_evaluator_defines.svh"

module cubic_bspline_evaluator import cbs_pkg::*; #(
   parameter int COEF_DEPTH = 64
) (
   input logic       clock,
   input logic       reset,
   cbs_req_if.sink   req_ch,
   cbs_rsp_if.source rsp_ch,
   cbs_csr_if.sink   csr_ch
);

   cfg_type     cfg_ff, cfg_in;
   seq_out_type seq;
   stat_type    stat;
   logic        req_fire;

   // register file
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_KNOT_START:  cfg_in.knot_start      = csr_ch.data;
            CSR_INV_SPACING: cfg_in.inverse_spacing = csr_ch.data;
            CSR_NODE_COUNT:  cfg_in.node_count      = csr_ch.data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.knot_start      <= KNOT_START_RESET;
         cfg_ff.inverse_spacing <= INV_SPACING_RESET;
         cfg_ff.node_count      <= NODE_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // control: fetch step owns the request channel
   assign req_ch.ready = seq.ctl.accept;
   assign req_fire     = req_ch.valid && req_ch.ready;

   cbs_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .seq   (seq)
   );

   cbs_datapath #(
      .COEF_DEPTH (COEF_DEPTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .ctl          (seq.ctl),
      .cfg          (cfg_ff),
      .req_fire     (req_fire),
      .command      (req_ch.command),
      .coef_index   (req_ch.coef_index),
      .coef_value   (req_ch.coef_value),
      .x_value      (req_ch.x_value),
      .rsp_ready    (rsp_ch.ready),
      .rsp_valid    (rsp_ch.valid),
      .spline_value (rsp_ch.spline_value),
      .stat         (stat)
   );

   `CBS_ASSERT_NEXT(a_eval_starts_program, clock, reset,
      req_fire && (req_ch.command == CMD_EVAL), seq.step == STEP_FIRST_WORK,
      "evaluate transfer did not start the program")
   `CBS_ASSERT_NEXT(a_load_stays_in_fetch, clock, reset,
      req_fire && (req_ch.command == CMD_LOAD), seq.step == STEP_FETCH,
      "load transfer left the fetch step")
   `CBS_ASSERT_IMPLY(a_busy_blocks_requests, clock, reset,
      seq.step != STEP_FETCH, !req_ch.ready,
      "request accepted while the program runs")
   `CBS_ASSERT_IMPLY(a_result_from_emit, clock, reset,
      $rose(rsp_ch.valid), $past(seq.step) == STEP_EMIT,
      "response raised outside the emit step")

endmodule
